@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// shared constants for the q24.8 fixed-point alu: opcodes, work kinds, sizes
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OP_W           = 4;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
  localparam logic [OP_W-1:0] OP_GT    = 4'd4;
  localparam logic [OP_W-1:0] OP_LT    = 4'd5;
  localparam logic [OP_W-1:0] OP_GE    = 4'd6;
  localparam logic [OP_W-1:0] OP_LE    = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ    = 4'd8;
  localparam logic [OP_W-1:0] OP_NE    = 4'd9;
  localparam logic [OP_W-1:0] OP_MIN   = 4'd10;
  localparam logic [OP_W-1:0] OP_MAX   = 4'd11;
  localparam logic [OP_W-1:0] OP_INC   = 4'd12;
  localparam logic [OP_W-1:0] OP_DEC   = 4'd13;
  localparam logic [OP_W-1:0] OP_TOINT = 4'd14;

  // what the back end still has to do with a word
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;

endpackage

@@ rtl/fpa_req_if.sv @@
// ----------------------------------------------------------------------------
// fpa_req_if
// request channel: opcode and two raw operands
// ----------------------------------------------------------------------------
interface fpa_req_if import fpa_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              opcode;
  logic signed [WORD_WIDTH-1:0] operand_a;
  logic signed [WORD_WIDTH-1:0] operand_b;

  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

@@ rtl/fpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fpa_rsp_if
// response channel: result word and flags
// ----------------------------------------------------------------------------
interface fpa_rsp_if import fpa_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] result_value;
  logic                         compare_true;
  logic                         divide_by_zero;
  logic                         overflow;

  modport source (output valid, result_value, compare_true, divide_by_zero, overflow,
                  input ready);
  modport sink   (input valid, result_value, compare_true, divide_by_zero, overflow,
                  output ready);
endinterface

@@ rtl/fixed_point_alu_q24_8.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// signed q24.8 fixed-point alu with exact rounded multiply and divide
// ----------------------------------------------------------------------------
// usage
//   req channel: opcode, operand_a, operand_b as raw two's-complement words;
//   a word is taken when valid and ready are both high
//   rsp channel: result_value, compare_true, divide_by_zero, overflow;
//   exactly one response word per request word, in request order
//   throughput: one word per cycle sustained while rsp.ready stays high, all opcodes alike
//   the back-end pipeline depth is set by the divider, which produces
//   one quotient bit per pipeline stage; every word walks the same stages
//   so order is kept without tags
//   all other ops (and div by zero) finish in the front end; mul and div finish in the back
//   reset: synchronous, clears the queue and all stage valid bits
//   stall: while rsp.ready is low and an output word waits, the back-end
//   pipeline holds; the queue keeps absorbing requests until full, then
//   req.ready drops
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);

  // one queued word: pre-classified op with any finished result
  typedef struct packed {
    logic [1:0]            kind;
    logic [WORD_WIDTH-1:0] a;
    logic [WORD_WIDTH-1:0] b;
    logic [WORD_WIDTH-1:0] res;
    logic                  cmp;
    logic                  dz;
    logic                  ov;
  } ent_t;

  ent_t wr_ent, rd_ent;
  logic push, full, pop, nempty;

  // front: accept and classify
  fpa_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ent_t      (ent_t)
  ) u_front (
    .req  (req),
    .full (full),
    .push (push),
    .ent  (wr_ent)
  );

  // decoupling queue
  fpa_queue #(
    .ent_t (ent_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (wr_ent),
    .full   (full),
    .pop    (pop),
    .rdata  (rd_ent),
    .nempty (nempty)
  );

  // back: multiply / divide pipeline and output register
  fpa_back #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ent_t      (ent_t)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (rd_ent),
    .nempty (nempty),
    .pop    (pop),
    .rsp    (rsp)
  );

endmodule

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// accepts requests, finishes all ops but mul and div, tags mul and div for the back end
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; #(
  parameter int  WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int  FRAC_BITS  = FRAC_BITS_DEF,
  parameter type ent_t      = logic
) (
  fpa_req_if.sink req,
  input  logic    full,
  output logic    push,
  output ent_t    ent
);

  localparam logic [WORD_WIDTH-1:0] MAXV = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] MINV = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [WORD_WIDTH-1:0] a, b, sum, dif;
  logic                  sa, sb, lt, gt, eq;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    a   = req.operand_a;
    b   = req.operand_b;
    sa  = a[WORD_WIDTH-1];
    sb  = b[WORD_WIDTH-1];
    sum = a + b;
    dif = a - b;
    lt  = $signed(a) < $signed(b);
    gt  = $signed(a) > $signed(b);
    eq  = a == b;

    ent      = '0;
    ent.kind = KIND_PASS;
    ent.a    = a;
    ent.b    = b;
    unique case (req.opcode)
      OP_ADD: begin
        ent.res = sum;
        if (sa == sb && sum[WORD_WIDTH-1] != sa) begin
          ent.ov  = 1'b1;
          ent.res = sa ? MINV : MAXV;
        end
      end
      OP_SUB: begin
        ent.res = dif;
        if (sa != sb && dif[WORD_WIDTH-1] != sa) begin
          ent.ov  = 1'b1;
          ent.res = sa ? MINV : MAXV;
        end
      end
      OP_MUL: ent.kind = KIND_MUL;
      OP_DIV: begin
        if (b == '0) ent.dz = 1'b1;
        else         ent.kind = KIND_DIV;
      end
      OP_GT:  ent.cmp = gt;
      OP_LT:  ent.cmp = lt;
      OP_GE:  ent.cmp = !lt;
      OP_LE:  ent.cmp = !gt;
      OP_EQ:  ent.cmp = eq;
      OP_NE:  ent.cmp = !eq;
      OP_MIN: ent.res = lt ? a : b;
      OP_MAX: ent.res = gt ? a : b;
      OP_INC: begin
        ent.ov  = a == MAXV;
        ent.res = (a == MAXV) ? MAXV : a + 1'b1;
      end
      OP_DEC: begin
        ent.ov  = a == MINV;
        ent.res = (a == MINV) ? MINV : a - 1'b1;
      end
      OP_TOINT: ent.res = $signed(a) >>> FRAC_BITS;
      default: ;
    endcase
  end

endmodule

@@ rtl/fpa_queue.sv @@
// ----------------------------------------------------------------------------
// fpa_queue
// small flop-based fifo between front and back end
// ----------------------------------------------------------------------------
module fpa_queue import fpa_pkg::*; #(
  parameter type ent_t = logic,
  parameter int  DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ent_t wdata,
  output logic full,
  input  logic pop,
  output ent_t rdata,
  output logic nempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ent_t          mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full   = count == CW'(DEPTH);
  assign nempty = count != '0;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

@@ rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// pipelined multiply and restoring divide, one quotient bit per stage
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; #(
  parameter int  WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int  FRAC_BITS  = FRAC_BITS_DEF,
  parameter type ent_t      = logic
) (
  input  logic     clk,
  input  logic     rst,
  input  ent_t     head,
  input  logic     nempty,
  output logic     pop,
  fpa_rsp_if.source rsp
);

  localparam int W  = WORD_WIDTH;
  localparam int N  = WORD_WIDTH + FRAC_BITS;   // quotient bits
  localparam int L  = WORD_WIDTH / 2;
  localparam int XW = 2 * WORD_WIDTH + FRAC_BITS + 1;
  localparam int S  = N + 2;                     // stages
  localparam int HS = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic [W-1:0]    MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]    MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [XW-1:0]   LIMP = XW'(MAXV);
  localparam logic [XW-1:0]   LIMN = XW'(MINV);
  localparam logic [2*W-1:0]  HALF = (FRAC_BITS > 0) ? ((2*W)'(1) << HS) : '0;

  typedef struct packed {
    logic           vld;
    logic [1:0]     kind;
    logic           neg;
    logic [W-1:0]   res;
    logic           cmp;
    logic           dz;
    logic           ov;
    logic [W:0]     pp0, pp1, pp2, pp3;
    logic [2*W-1:0] prod;
    logic [N-1:0]   num;
    logic [N-1:0]   quo;
    logic [W-1:0]   rem;
    logic [W-1:0]   d;
  } stage_t;

  stage_t stg [S];
  stage_t nxt [S];
  logic   adv;

  // saturate a magnitude and apply the sign: {ov, value}
  function automatic logic [W:0] finish(input logic neg, input logic [XW-1:0] mag);
    logic [W-1:0] v;
    v = mag[W-1:0];
    if (mag > (neg ? LIMN : LIMP)) return {1'b1, neg ? MINV : MAXV};
    return {1'b0, neg ? -v : v};
  endfunction

  assign adv = !stg[S-1].vld || rsp.ready;
  assign pop = adv && nempty;

  // entry stage: magnitudes, partial products, divider setup
  always_comb begin
    logic [W-1:0] ma, mb;
    ma = head.a[W-1] ? -head.a : head.a;
    mb = head.b[W-1] ? -head.b : head.b;
    nxt[0]      = '0;
    nxt[0].vld  = nempty;
    nxt[0].kind = head.kind;
    nxt[0].neg  = head.a[W-1] ^ head.b[W-1];
    nxt[0].res  = head.res;
    nxt[0].cmp  = head.cmp;
    nxt[0].dz   = head.dz;
    nxt[0].ov   = head.ov;
    nxt[0].pp0  = (W+1)'(ma[L-1:0]) * (W+1)'(mb[L-1:0]);
    nxt[0].pp1  = (W+1)'(ma[L-1:0]) * (W+1)'(mb[W-1:L]);
    nxt[0].pp2  = (W+1)'(ma[W-1:L]) * (W+1)'(mb[L-1:0]);
    nxt[0].pp3  = (W+1)'(ma[W-1:L]) * (W+1)'(mb[W-1:L]);
    nxt[0].num  = N'(ma) << FRAC_BITS;
    nxt[0].d    = mb;
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    always_comb begin
      logic [W-1:0]   sh;
      logic           ge;
      logic [2*W-1:0] rnd;
      logic [W:0]     fin;
      nxt[k] = stg[k-1];
      sh  = {stg[k-1].rem[W-2:0], stg[k-1].num[N-1]};
      ge  = sh >= stg[k-1].d;
      rnd = (stg[k-1].prod + HALF) >> FRAC_BITS;
      fin = finish(stg[k-1].neg, XW'(rnd));
      if (stg[k-1].kind == KIND_DIV) begin
        nxt[k].rem = ge ? sh - stg[k-1].d : sh;
        nxt[k].quo = {stg[k-1].quo[N-2:0], ge};
        nxt[k].num = stg[k-1].num << 1;
      end else if (stg[k-1].kind == KIND_MUL && k == 1) begin
        nxt[k].prod = (2*W)'(stg[k-1].pp0)
                    + (((2*W)'(stg[k-1].pp1) + (2*W)'(stg[k-1].pp2)) << L)
                    + ((2*W)'(stg[k-1].pp3) << (2*L));
      end else if (stg[k-1].kind == KIND_MUL && k == 2) begin
        nxt[k].kind = KIND_PASS;
        nxt[k].ov   = fin[W];
        nxt[k].res  = fin[W-1:0];
      end
    end
  end

  // divide rounding: half away from zero when 2*rem >= d
  always_comb begin
    logic [N:0] q;
    logic [W:0] fin;
    q   = (N+1)'(stg[N].quo) + (N+1)'({stg[N].rem, 1'b0} >= (W+1)'(stg[N].d));
    fin = finish(stg[N].neg, XW'(q));
    nxt[S-1] = stg[N];
    if (stg[N].kind == KIND_DIV) begin
      nxt[S-1].kind = KIND_PASS;
      nxt[S-1].ov   = fin[W];
      nxt[S-1].res  = fin[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < S; i++) stg[i].vld <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < S; i++) stg[i] <= nxt[i];
    end
  end

  assign rsp.valid          = stg[S-1].vld;
  assign rsp.result_value   = stg[S-1].res;
  assign rsp.compare_true   = stg[S-1].cmp;
  assign rsp.divide_by_zero = stg[S-1].dz;
  assign rsp.overflow       = stg[S-1].ov;

endmodule
